// ===== hdl/llra_pkg.sv =====
package llra_pkg;

  localparam int MAX_ROWS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int LOAD_W   = 16;
  localparam int WIDTH_W  = 10;
  localparam int PAD_W    = 8;
  localparam int RCNT_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int SUM_W    = LOAD_W + 2;

  localparam logic [LOAD_W-1:0] LOAD_SAT = {LOAD_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_PADDING   = 1'b1
  } cfg_reg_t;

  // one row load (from the memory, or the set padding for an unwritten row) for the minimum search
  typedef struct packed {
    logic              vld;
    logic [ROW_W-1:0]  idx;
    logic [LOAD_W-1:0] load;
  } scan_smp_t;

endpackage

// ===== hdl/llra_row_mem.sv =====
module llra_row_mem
  import llra_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_addr,
  input  logic [LOAD_W-1:0] wr_data,
  input  logic [ROW_W-1:0]  rd_addr,
  output logic [LOAD_W-1:0] rd_data
);

  logic [LOAD_W-1:0] mem [MAX_ROWS];
  logic [LOAD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/llra_min_scan.sv =====
module llra_min_scan
  import llra_pkg::*;
(
  input  logic              clk,
  input  scan_smp_t         smp,
  output logic [ROW_W-1:0]  best_idx,
  output logic [LOAD_W-1:0] best_load
);

  logic [ROW_W-1:0]  best_idx_r;
  logic [LOAD_W-1:0] best_load_r;

  // row 0 opens the search; ties keep the lower row
  always_ff @(posedge clk) begin
    if (smp.vld && (smp.idx == '0 || smp.load < best_load_r)) begin
      best_idx_r  <= smp.idx;
      best_load_r <= smp.load;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_load = best_load_r;

endmodule

// ===== hdl/least_loaded_row_assigner.sv =====
// channel | direction | handshake           | word
// in      | input     | in_valid / in_stall | in_item_width, in_last_item
// out     | output    | out_valid/out_stall | out_row_index, out_max_load, out_set_done
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item is accepted, then its n row loads are read from the row memory, one
// per cycle (n being the active row count, 1..16), then drained and written.
// rst_n is synchronous; it clears control state and padding, and sets one row.
// A result waits in the output register under out_stall while the next item
// is scanned; the write-back waits only while that register is full and stalled.
module least_loaded_row_assigner
  import llra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WIDTH_W-1:0]    in_item_width,
  input  logic                  in_last_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_row_index,
  output logic [LOAD_W-1:0]     out_max_load,
  output logic                  out_set_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [RCNT_W-1:0] row_count_r;
  logic [PAD_W-1:0]  padding_r;
  logic [PAD_W-1:0]  set_pad_r;
  logic              set_open_r;
  logic [MAX_ROWS-1:0] vld_r;
  logic [LOAD_W-1:0] max_r;
  logic [WIDTH_W-1:0] width_r;
  logic              last_r;
  logic [ROW_W-1:0]  last_idx_r;
  logic [ROW_W-1:0]  rd_addr_r;
  logic              smp_vld_r;
  logic [ROW_W-1:0]  smp_idx_r;
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [LOAD_W-1:0] out_max_r;
  logic              out_done_r;

  logic              in_fire;
  logic              out_free;
  logic              wr_en;
  logic [LOAD_W-1:0] rd_data;
  logic [ROW_W-1:0]  best_idx;
  logic [LOAD_W-1:0] best_load;
  logic [ROW_W-1:0]  last_idx;
  logic [SUM_W-1:0]  sum;
  logic [LOAD_W-1:0] sum_sat;
  logic [LOAD_W-1:0] max_nxt;
  scan_smp_t         smp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_en     = (state_r == S_DONE) && out_free;

  always_comb begin
    if (row_count_r == '0) begin
      last_idx = '0;
    end else if (row_count_r > RCNT_W'(MAX_ROWS)) begin
      last_idx = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_idx = ROW_W'(row_count_r - RCNT_W'(1));
    end
  end

  assign smp.vld  = smp_vld_r;
  assign smp.idx  = smp_idx_r;
  assign smp.load = vld_r[smp_idx_r] ? rd_data : LOAD_W'(set_pad_r);

  assign sum     = SUM_W'(best_load) + SUM_W'(width_r) + SUM_W'(padding_r);
  assign sum_sat = (|sum[SUM_W-1:LOAD_W]) ? LOAD_SAT : sum[LOAD_W-1:0];
  assign max_nxt = (sum_sat > max_r) ? sum_sat : max_r;

  llra_row_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (best_idx),
    .wr_data (sum_sat),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  llra_min_scan u_scan (
    .clk       (clk),
    .smp       (smp),
    .best_idx  (best_idx),
    .best_load (best_load)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= RCNT_W'(1);
      padding_r   <= '0;
      set_open_r  <= 1'b0;
      vld_r       <= '0;
      smp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count_r <= cfg_data[RCNT_W-1:0];
          REG_PADDING:   padding_r   <= cfg_data[PAD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && !wr_en) begin
        out_valid_r <= 1'b0;
      end
      smp_vld_r <= (state_r == S_SCAN);
      smp_idx_r <= rd_addr_r;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            width_r    <= in_item_width;
            last_r     <= in_last_item;
            last_idx_r <= last_idx;
            rd_addr_r  <= '0;
            if (!set_open_r) begin
              set_open_r <= 1'b1;
              vld_r      <= '0;
              set_pad_r  <= padding_r;
              max_r      <= LOAD_W'(padding_r);
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_addr_r == last_idx_r) begin
            state_r <= S_DRAIN;
          end else begin
            rd_addr_r <= rd_addr_r + ROW_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            vld_r[best_idx] <= 1'b1;
            max_r       <= max_nxt;
            out_valid_r <= 1'b1;
            out_row_r   <= best_idx;
            out_max_r   <= max_nxt;
            out_done_r  <= last_r;
            if (last_r) begin
              set_open_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_max_load  = out_max_r;
  assign out_set_done  = out_done_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_addr_r <= last_idx_r))
    else $error("row read beyond active rows");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (best_idx <= last_idx_r))
    else $error("chosen row beyond active rows");

  a_result_max: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (out_valid_r && out_max_r >= $past(sum_sat) && out_row_r == $past(best_idx)))
    else $error("result does not follow write-back");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_max_r) && $stable(out_row_r)))
    else $error("pending result overwritten");

endmodule

// ===== dv/row_assign_checker.sv =====
module row_assign_checker
  import llra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [WIDTH_W-1:0]    in_item_width,
  input  logic                  in_last_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [ROW_W-1:0]      out_row_index,
  input  logic [LOAD_W-1:0]     out_max_load,
  input  logic                  out_set_done,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [LOAD_W-1:0] max_load;
    logic              done;
  } placement_t;

  placement_t        placements_due[$];
  logic [RCNT_W-1:0] row_count_q;
  logic [PAD_W-1:0]  padding_q;
  logic [LOAD_W-1:0] row_load [MAX_ROWS];
  logic [LOAD_W-1:0] peak_load;
  logic              set_open;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic place_item(input logic [WIDTH_W-1:0] width, input logic last);
    int unsigned rows;
    int unsigned best;
    int unsigned sum;
    placement_t  p;
    if (!set_open) begin
      foreach (row_load[i]) row_load[i] = LOAD_W'(padding_q);
      peak_load = LOAD_W'(padding_q);
      set_open  = 1'b1;
    end
    rows = 32'(row_count_q);
    if (rows == 0) rows = 1;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    best = 0;
    for (int i = 1; i < rows; i++) begin
      if (row_load[i] < row_load[best]) best = i;
    end
    sum = 32'(row_load[best]) + 32'(width) + 32'(padding_q);
    if (sum > 32'(LOAD_SAT)) sum = 32'(LOAD_SAT);
    row_load[best] = sum[LOAD_W-1:0];
    if (sum > 32'(peak_load)) peak_load = sum[LOAD_W-1:0];
    p.row      = best[ROW_W-1:0];
    p.max_load = peak_load;
    p.done     = last;
    placements_due.insert(placements_due.size(), p);
    if (last) set_open = 1'b0;
  endtask

  always @(posedge clk) begin
    placement_t due;
    if (!rst_n) begin
      row_count_q = RCNT_W'(1);
      padding_q   = '0;
      foreach (row_load[i]) row_load[i] = '0;
      peak_load   = '0;
      set_open    = 1'b0;
      placements_due.delete();
      errors      = 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count_q = cfg_data[RCNT_W-1:0];
          REG_PADDING:   padding_q   = cfg_data[PAD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          report("result word with none expected");
        end else begin
          due = placements_due.pop_front();
          if (out_row_index !== due.row)
            report($sformatf("row_index got %0d want %0d", out_row_index, due.row));
          if (out_max_load !== due.max_load)
            report($sformatf("max_load got %0d want %0d", out_max_load, due.max_load));
          if (out_set_done !== due.done)
            report($sformatf("set_done got %0b want %0b", out_set_done, due.done));
        end
      end
      if (in_valid && !in_stall) place_item(in_item_width, in_last_item);
      pending <= placements_due.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import llra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [WIDTH_W-1:0]    in_item_width = '0;
  logic                  in_last_item  = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [ROW_W-1:0]      out_row_index;
  logic [LOAD_W-1:0]     out_max_load;
  logic                  out_set_done;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  int                    errors;
  int                    pending;
  int                    words_sent    = 0;

  always #1 clk = ~clk;

  least_loaded_row_assigner u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item_width (in_item_width),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_max_load  (out_max_load),
    .out_set_done  (out_set_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  row_assign_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item_width (in_item_width),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_max_load  (out_max_load),
    .out_set_done  (out_set_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width(input bit heavy);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (heavy) return WIDTH_W'($urandom_range(896, 1023));
    if (r == 0) return '0;
    if (r == 1) return '1;
    return WIDTH_W'($urandom_range(0, 1023));
  endfunction

  task automatic send_word(input logic [WIDTH_W-1:0] width, input logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_item_width <= width;
    in_last_item  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [RCNT_W-1:0] rows, input logic [PAD_W-1:0] pad);
    logic [CFG_DATA_W-RCNT_W-1:0] upper;
    upper      = (CFG_DATA_W-RCNT_W)'($urandom_range(0, 7));
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= {upper, rows};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_PADDING;
    cfg_data  <= pad;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && words_sent >= 40) begin
        held       = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      if ($urandom_range(0, 1) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (gap_len() + 1) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    bit          heavy;
    int unsigned rows;
    int unsigned pad;
    int unsigned sets;
    int unsigned len;
    logic        last;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one row, no padding
    send_word(10'd0, 1'b0);
    send_word(10'd1023, 1'b1);
    drain();
    // zero row count acts as one row, full padding
    configure(5'd0, 8'd255);
    send_word(10'd1023, 1'b0);
    send_word(10'd0, 1'b1);
    drain();
    // row count above limit, set left open
    configure(5'd17, 8'd0);
    send_word(10'd0, 1'b0);
    send_word(10'd0, 1'b0);
    send_word(10'd1023, 1'b0);
    send_word(10'd512, 1'b0);
    drain();
    // row count and padding changed mid-set
    configure(5'd3, 8'd7);
    send_word(10'd10, 1'b0);
    send_word(10'd10, 1'b0);
    send_word(10'd10, 1'b1);
    drain();
    configure(5'd2, 8'd1);
    send_word(10'h2AA, 1'b0);
    send_word(10'h155, 1'b1);
    drain();

    while (words_sent < 1600) begin
      heavy = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0:       rows = 0;
        1:       rows = 1;
        2:       rows = 16;
        3:       rows = $urandom_range(17, 31);
        default: rows = $urandom_range(2, 15);
      endcase
      case ($urandom_range(0, 3))
        0:       pad = 0;
        1:       pad = 255;
        default: pad = $urandom_range(0, 255);
      endcase
      // long sets on few rows drive the loads into saturation
      if (heavy) begin
        rows = $urandom_range(0, 2);
        pad  = $urandom_range(128, 255);
      end
      configure(RCNT_W'(rows), PAD_W'(pad));
      sets = heavy ? 1 : $urandom_range(2, 8);
      for (int s = 0; s < sets; s++) begin
        if (heavy) len = $urandom_range(50, 120);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(10, 40);
        else len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1);
          if (last && s == sets - 1 && $urandom_range(0, 3) == 0) last = 1'b0;
          send_word(pick_width(heavy), last);
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
